FILE: src/rfxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfxf_pkg
// Types and constants for the receive FIFO with XON/XOFF flow control.
// ----------------------------------------------------------------------------
package rfxf_pkg;

  localparam int unsigned FifoDepthDefault = 8;

  // flow control characters (DC1 / DC3)
  localparam logic [7:0] CodeXon  = 8'h11;
  localparam logic [7:0] CodeXoff = 8'h13;

  // commands
  localparam logic CmdReceive = 1'b0;
  localparam logic CmdConsume = 1'b1;

  // configuration register indexes and reset values
  localparam logic RegUpperLimit = 1'b0;
  localparam logic RegLowerLimit = 1'b1;
  localparam logic [3:0] UpperLimitReset = 4'd6;
  localparam logic [3:0] LowerLimitReset = 4'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       flow_valid;
    logic [7:0] flow_byte;
    logic       overflow;
    logic [3:0] fill_level;
  } out_item_t;

endpackage

FILE: src/rx_fifo_xon_xoff_flow_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_fifo_xon_xoff_flow_control
// Receive byte FIFO that emits XOFF/XON characters around two fill limits.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken on a rising edge with start high and busy
//   low. command 0 pushes data_byte, command 1 pops the oldest byte. busy
//   stays low, so one command can be issued every cycle.
//   Each command yields one result, shown on result_o for exactly one cycle
//   with result_valid_o high, in the cycle after the command was taken. The
//   receiver cannot stall; the result is taken at the edge ending that cycle.
//   The bytes sit in a synchronous RAM of FifoDepth entries with a registered
//   read; its read data register feeds read_byte, gated by read_valid.
//   Pointers and the count live in flops next to it and are updated in the
//   cycle the command is taken.
//   A push to a full FIFO drops the byte and flags overflow; a pop from an
//   empty FIFO returns read_valid low. XOFF follows a push that leaves the
//   fill level at or above upper_limit, XON a pop that leaves it at or below
//   lower_limit.
//   The APB port holds upper_limit at 0x0 and lower_limit at 0x4. Reset
//   empties the FIFO, restores the limits to 6 and 2 and drops any result.
// ----------------------------------------------------------------------------
module rx_fifo_xon_xoff_flow_control #(
  parameter int unsigned FifoDepth = rfxf_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rfxf_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output rfxf_pkg::out_item_t result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rfxf_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam int unsigned CmpW = (CntW > 4) ? CntW : 4;

  logic [7:0]      mem [FifoDepth];
  logic [7:0]      rdata_q;

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [3:0]      upper_q, lower_q;

  logic            res_valid_q;
  logic            rd_valid_q, rd_valid_d;
  logic            flow_valid_q, flow_valid_d;
  logic [7:0]      flow_byte_q, flow_byte_d;
  logic            ovf_q, ovf_d;
  logic [3:0]      fill_q;

  logic            accept;
  logic            full;
  logic            empty;
  logic            do_push;
  logic            do_pop;
  logic [CmpW-1:0] count_ext;
  logic            cfg_wr;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(FifoDepth));
  assign empty  = (count_q == '0);
  assign do_push = accept && (item_i.command == CmdReceive) && !full;
  assign do_pop  = accept && (item_i.command == CmdConsume) && !empty;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] slot);
    next_slot = (slot == PtrW'(FifoDepth - 1)) ? '0 : slot + 1'b1;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d  = next_slot(tail_q);
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      head_d  = next_slot(head_q);
      count_d = count_q - 1'b1;
    end
  end

  assign count_ext = CmpW'(count_d);

  always_comb begin
    rd_valid_d   = do_pop;
    ovf_d        = 1'b0;
    flow_valid_d = 1'b0;
    flow_byte_d  = 8'h00;
    if (item_i.command == CmdReceive) begin
      ovf_d = full;
      if (count_ext >= CmpW'(upper_q)) begin
        flow_valid_d = 1'b1;
        flow_byte_d  = CodeXoff;
      end
    end else if (do_pop && (count_ext <= CmpW'(lower_q))) begin
      flow_valid_d = 1'b1;
      flow_byte_d  = CodeXon;
    end
  end

  // byte store: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= item_i.data_byte;
    end
    if (do_pop) begin
      rdata_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      res_valid_q <= accept;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_valid_q   <= rd_valid_d;
      flow_valid_q <= flow_valid_d;
      flow_byte_q  <= flow_byte_d;
      ovf_q        <= ovf_d;
      fill_q       <= count_ext[3:0];
    end
  end

  assign result_valid_o        = res_valid_q;
  assign result_o.read_byte    = rd_valid_q ? rdata_q : 8'h00;
  assign result_o.read_valid   = rd_valid_q;
  assign result_o.flow_valid   = flow_valid_q;
  assign result_o.flow_byte    = flow_byte_q;
  assign result_o.overflow     = ovf_q;
  assign result_o.fill_level   = fill_q;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UpperLimitReset;
      lower_q <= LowerLimitReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegUpperLimit) begin
        upper_q <= pwdata[3:0];
      end else begin
        lower_q <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegLowerLimit) begin
      prdata = {28'd0, lower_q};
    end else begin
      prdata = {28'd0, upper_q};
    end
  end

endmodule
